>>> rtl/gbmbo_pkg.sv
// Shared constants, types and a helper function for the binary option Monte Carlo unit.
`default_nettype none

package gbmbo_pkg;

  // Number of uniform draws summed into one approximately normal value.
  localparam int DRAWS_PER_NORMAL = 12;
  // Significant bits of each random word.
  localparam int RANDOM_BITS = 16;

  localparam int WORD_W = 16;
  localparam int WORD_USE = (RANDOM_BITS < WORD_W) ? RANDOM_BITS : WORD_W;
  localparam int SUM_W = RANDOM_BITS + 4;
  localparam int CNT_W = $clog2(DRAWS_PER_NORMAL + 1);
  localparam int RB_DOWN = (RANDOM_BITS > 16) ? (RANDOM_BITS - 16) : 0;
  localparam int RB_UP = (RANDOM_BITS < 16) ? (16 - RANDOM_BITS) : 0;

  // Datapath widths of the price step.
  localparam int MAG_W = 19;
  localparam int ZPROD_W = 32 + MAG_W;
  localparam int ZMAG_W = ZPROD_W - 16;
  localparam int TPROD_W = 32 + ZMAG_W;
  localparam int TMAG_W = TPROD_W - 30;
  localparam int FACT_W = TMAG_W + 2;
  localparam int FU_W = FACT_W - 1;
  localparam int PLO_W = 62;
  localparam int NP_W = 32 + (FU_W - 30) + 1;

  // Estimate division widths.
  localparam int EST_W = 16;
  localparam int DVS_W = 24;
  localparam int DVD_W = EST_W + DVS_W;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  // Exact integer square root, evaluated at elaboration only.
  function automatic logic [31:0] isqrt64(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bv;
    rem = n;
    res = '0;
    bv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bv) begin
        rem = rem - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res[31:0];
  endfunction

  localparam logic [31:0] SCALE = isqrt64(64'(12 / DRAWS_PER_NORMAL) << 60);
  localparam logic [SUM_W-1:0] OFFSET = SUM_W'(DRAWS_PER_NORMAL / 2) << RANDOM_BITS;
  localparam logic signed [FACT_W-1:0] ONE_Q30 = FACT_W'(1) << 30;

  typedef enum logic [2:0] {
    REG_DRIFT     = 3'd0,
    REG_DIFFUSION = 3'd1,
    REG_SPOT      = 3'd2,
    REG_STRIKE    = 3'd3,
    REG_STEPS     = 3'd4,
    REG_PATHS     = 3'd5,
    REG_DISCOUNT  = 3'd6,
    REG_PUT       = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic signed [31:0] drift;
    logic signed [31:0] diffusion;
    logic [31:0]        spot;
    logic [31:0]        strike;
    logic [15:0]        steps;
    logic [23:0]        paths;
    logic [15:0]        discount;
    logic               put_sel;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    drift:     32'sd26844,
    diffusion: 32'sd4801920,
    spot:      32'd6553600,
    strike:    32'd6553600,
    steps:     16'd2000,
    paths:     24'd100,
    discount:  16'd62340,
    put_sel:   1'b0
  };

  typedef struct packed {
    logic [31:0]      final_price;
    logic             in_the_money;
    logic             batch_done;
    logic [EST_W-1:0] payoff_estimate;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

>>> rtl/gbm_binary_option_monte_carlo_unit.sv
// Top level of the binary option Monte Carlo unit: configuration registers and queue wiring.
//
// Each accepted random word is one uniform draw; twelve draws form one normal sample
// and advance the path price by one step. The front end takes one word per cycle while
// full is low and hands each finished sum to a two-entry queue; the back end runs one
// price step through a chain of five registered multiply stages, and a step's twelve
// words at one per cycle keep it fed, so full rises only when the back end falls
// behind. A path end passes through the batch and output states and waits for a free
// slot in the two-entry result queue, and a batch end also waits for the bit-serial
// division of the estimate. Configuration writes take effect on the next cycle and
// are meant for times when no path step is in flight.
`default_nettype none

module gbm_binary_option_monte_carlo_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] random_word,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] final_price,
  output logic        in_the_money,
  output logic        batch_done,
  output logic [15:0] payoff_estimate,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import gbmbo_pkg::*;

  cfg_t             cfg;
  logic             sum_valid;
  logic [SUM_W-1:0] sum_data;
  logic             sum_take;
  logic             res_valid;
  result_t          res_data;
  logic             res_full;
  result_t          out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DRIFT:     cfg.drift <= cfg_data;
        REG_DIFFUSION: cfg.diffusion <= cfg_data;
        REG_SPOT:      cfg.spot <= cfg_data;
        REG_STRIKE:    cfg.strike <= cfg_data;
        REG_STEPS:     cfg.steps <= cfg_data[15:0];
        REG_PATHS:     cfg.paths <= cfg_data[23:0];
        REG_DISCOUNT:  cfg.discount <= cfg_data[15:0];
        REG_PUT:       cfg.put_sel <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  gbmbo_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .random_word (random_word),
    .full        (full),
    .sum_valid   (sum_valid),
    .sum_data    (sum_data),
    .sum_take    (sum_take)
  );

  gbmbo_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .sum_valid (sum_valid),
    .sum_data  (sum_data),
    .sum_take  (sum_take),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (!res_full)
  );

  gbmbo_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_data   (res_data),
    .in_full   (res_full),
    .out_pop   (pop),
    .out_empty (empty),
    .out_data  (out_data)
  );

  assign final_price = out_data.final_price;
  assign in_the_money = out_data.in_the_money;
  assign batch_done = out_data.batch_done;
  assign payoff_estimate = out_data.payoff_estimate;

endmodule

`default_nettype wire

>>> rtl/gbmbo_front.sv
// Front end: accumulates uniform draws and queues each finished sum for the back end.
`default_nettype none

module gbmbo_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [15:0]                 random_word,
  output logic                        full,
  output logic                        sum_valid,
  output logic [gbmbo_pkg::SUM_W-1:0] sum_data,
  input  logic                        sum_take
);
  import gbmbo_pkg::*;

  logic [SUM_W-1:0] uniform_sum;
  logic [CNT_W-1:0] draw_count;
  logic [SUM_W-1:0] q_data [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       q_count;

  logic [SUM_W-1:0] draw;
  logic             last_draw;
  logic             accept;
  logic             q_push;
  logic             q_pop;

  always_comb begin
    draw = SUM_W'(random_word[WORD_USE-1:0]) + SUM_W'(1);
    last_draw = (draw_count == CNT_W'(DRAWS_PER_NORMAL - 1));
    // Only the draw that completes a sum needs room in the queue.
    full = last_draw && (q_count == 2'd2);
    accept = push && !full;
    q_push = accept && last_draw;
    q_pop = sum_take && (q_count != 2'd0);
  end

  assign sum_valid = (q_count != 2'd0);
  assign sum_data = q_data[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      uniform_sum <= '0;
      draw_count <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      q_count <= 2'd0;
    end else begin
      if (accept) begin
        if (last_draw) begin
          uniform_sum <= '0;
          draw_count <= '0;
        end else begin
          uniform_sum <= uniform_sum + draw;
          draw_count <= draw_count + CNT_W'(1);
        end
      end
      if (q_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      q_count <= q_count + 2'(q_push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_data[wr_ptr] <= uniform_sum + draw;
    end
  end

endmodule

`default_nettype wire

>>> rtl/gbmbo_div.sv
// Restoring divider, one quotient bit per cycle, for the batch estimate.
`default_nettype none

module gbmbo_div (
  input  logic                        clk,
  input  logic                        rst,
  input  gbmbo_pkg::div_req_t         req,
  output logic                        done,
  output logic [gbmbo_pkg::EST_W-1:0] quotient
);
  import gbmbo_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] left;
  logic [DVS_W-1:0]     rem;
  logic [DVS_W-1:0]     divisor;
  logic [DVD_W-1:0]     dvd;

  logic [DVS_W:0] trial;
  logic [DVS_W:0] diff;
  logic           ge;

  always_comb begin
    trial = {rem, dvd[DVD_W-1]};
    diff = trial - {1'b0, divisor};
    ge = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        left <= DIV_CNT_W'(DVD_W);
      end else if (busy) begin
        left <= left - DIV_CNT_W'(1);
        if (left == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Only the low quotient bits are kept; higher bits shift out.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= req.dividend;
      divisor <= req.divisor;
      quotient <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd <= dvd << 1;
      quotient <= {quotient[EST_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

>>> rtl/gbmbo_back.sv
// Back end: price step sequencer, path and batch bookkeeping, and result assembly.
`default_nettype none

module gbmbo_back (
  input  logic                        clk,
  input  logic                        rst,
  input  gbmbo_pkg::cfg_t             cfg,
  input  logic                        sum_valid,
  input  logic [gbmbo_pkg::SUM_W-1:0] sum_data,
  output logic                        sum_take,
  output logic                        res_valid,
  output gbmbo_pkg::result_t          res_data,
  input  logic                        res_ready
);
  import gbmbo_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_ZMAG  = 11'b000_0000_0010,
    ST_TLO   = 11'b000_0000_0100,
    ST_TSUM  = 11'b000_0000_1000,
    ST_FACT  = 11'b000_0001_0000,
    ST_PLO   = 11'b000_0010_0000,
    ST_PRICE = 11'b000_0100_0000,
    ST_PATH  = 11'b000_1000_0000,
    ST_BATCH = 11'b001_0000_0000,
    ST_DIV   = 11'b010_0000_0000,
    ST_OUT   = 11'b100_0000_0000
  } back_state_t;

  back_state_t state;

  logic [31:0] path_price;
  logic [15:0] step_count;
  logic [23:0] hit_count;
  logic [23:0] path_count;

  logic              zneg;
  logic [MAG_W-1:0]  mag;
  logic [ZMAG_W-1:0] zmag;
  logic              dneg;
  logic [31:0]       dmag;
  logic [63:0]       tlo;
  logic [TMAG_W-1:0] tmag;
  logic [FU_W-1:0]   fact;
  logic [PLO_W-1:0]  plo;
  result_t           res;

  logic                       zneg_c;
  logic [SUM_W-1:0]           absd;
  logic [SUM_W+RB_UP-1:0]     mag_w;
  logic [ZPROD_W-1:0]         zprod;
  logic [TPROD_W-1:0]         tprod;
  logic signed [FACT_W-1:0]   drift_x;
  logic signed [FACT_W-1:0]   term;
  logic signed [FACT_W-1:0]   f;
  logic [NP_W-1:0]            np;
  logic [31:0]                price_next;
  logic [15:0]                path_len;
  logic [23:0]                batch_len;
  logic                       hit;
  logic                       batch_end;
  div_req_t                   div_req;
  logic                       div_done;
  logic [EST_W-1:0]           div_quot;

  always_comb begin
    zneg_c = (sum_data < OFFSET);
    absd = zneg_c ? (OFFSET - sum_data) : (sum_data - OFFSET);
    // Bring the deviation to 16 fraction bits.
    mag_w = (SUM_W + RB_UP)'(absd >> RB_DOWN) << RB_UP;
    zprod = ZPROD_W'(SCALE) * ZPROD_W'(mag);
    tprod = TPROD_W'(tlo) +
            ((TPROD_W'(dmag) * TPROD_W'(zmag[ZMAG_W-1:32])) << 32);
    drift_x = {{(FACT_W - 32){cfg.drift[31]}}, cfg.drift};
    term = (zneg ^ dneg) ? -FACT_W'(tmag) : FACT_W'(tmag);
    f = ONE_Q30 + drift_x + term;
    np = NP_W'(path_price) * NP_W'(fact[FU_W-1:30]) + NP_W'(plo[PLO_W-1:30]);
    price_next = (|np[NP_W-1:32]) ? 32'hFFFF_FFFF : np[31:0];
    path_len = (cfg.steps < 16'd2) ? 16'd2 : cfg.steps;
    batch_len = (cfg.paths == 24'd0) ? 24'd1 : cfg.paths;
    hit = cfg.put_sel ? (path_price <= cfg.strike) : (path_price > cfg.strike);
    batch_end = (path_count >= batch_len) && (path_count != 24'd0);
    div_req.start = (state == ST_BATCH) && batch_end;
    div_req.dividend = DVD_W'(cfg.discount) * DVD_W'(hit_count);
    div_req.divisor = path_count;
  end

  assign sum_take = (state == ST_IDLE);
  assign res_valid = (state == ST_OUT);
  assign res_data = res;

  gbmbo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      path_price <= CFG_RESET.spot;
      step_count <= 16'd1;
      hit_count <= '0;
      path_count <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (sum_valid) begin
            state <= ST_ZMAG;
          end
        end
        ST_ZMAG:  state <= ST_TLO;
        ST_TLO:   state <= ST_TSUM;
        ST_TSUM:  state <= ST_FACT;
        ST_FACT:  state <= ST_PLO;
        ST_PLO:   state <= ST_PRICE;
        ST_PRICE: begin
          path_price <= price_next;
          step_count <= step_count + 16'd1;
          state <= ST_PATH;
        end
        ST_PATH: begin
          if (step_count < path_len) begin
            state <= ST_IDLE;
          end else begin
            hit_count <= hit_count + 24'(hit);
            path_count <= path_count + 24'd1;
            path_price <= cfg.spot;
            step_count <= 16'd1;
            state <= ST_BATCH;
          end
        end
        ST_BATCH: begin
          if (batch_end) begin
            hit_count <= '0;
            path_count <= '0;
            state <= ST_DIV;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        zneg <= zneg_c;
        mag <= MAG_W'(mag_w);
      end
      ST_ZMAG: begin
        zmag <= zprod[ZPROD_W-1:16];
        dneg <= cfg.diffusion[31];
        dmag <= cfg.diffusion[31] ? (32'd0 - cfg.diffusion) : cfg.diffusion;
      end
      ST_TLO: tlo <= 64'(dmag) * 64'(zmag[31:0]);
      ST_TSUM: tmag <= tprod[TPROD_W-1:30];
      ST_FACT: fact <= f[FACT_W-1] ? '0 : f[FU_W-1:0];
      ST_PLO: plo <= PLO_W'(path_price) * PLO_W'(fact[29:0]);
      ST_PATH: begin
        res.final_price <= path_price;
        res.in_the_money <= hit;
        res.batch_done <= 1'b0;
        res.payoff_estimate <= '0;
      end
      ST_BATCH: begin
        if (batch_end) begin
          res.batch_done <= 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res.payoff_estimate <= div_quot;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/gbmbo_outq.sv
// Two-entry result queue that decouples the back end from the consumer.
`default_nettype none

module gbmbo_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  gbmbo_pkg::result_t in_data,
  output logic               in_full,
  input  logic               out_pop,
  output logic               out_empty,
  output gbmbo_pkg::result_t out_data
);
  import gbmbo_pkg::*;

  result_t    q_data [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] q_count;
  logic       q_push;
  logic       q_pop;

  always_comb begin
    in_full = (q_count == 2'd2);
    out_empty = (q_count == 2'd0);
    q_push = in_valid && !in_full;
    q_pop = out_pop && !out_empty;
  end

  assign out_data = q_data[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      q_count <= 2'd0;
    end else begin
      if (q_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      q_count <= q_count + 2'(q_push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_data[wr_ptr] <= in_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/gbmbo_checker.sv
// Port-level checker for the binary option Monte Carlo unit and its bind.
`default_nettype none

module gbmbo_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] final_price,
  input logic        in_the_money,
  input logic        batch_done,
  input logic [15:0] payoff_estimate
);

  // A result that does not close a batch carries no estimate.
  a_estimate_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !batch_done) |-> (payoff_estimate == 16'd0))
    else $error("payoff_estimate is nonzero on a result without batch_done");

  // The input side can only fill up through an accepted transaction.
  a_full_needs_push: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(full)) |-> $past(push))
    else $error("full rose without a preceding push");

  // The result queue can only drain through a pop.
  a_empty_needs_pop: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(empty)) |-> $past(pop))
    else $error("empty rose without a preceding pop");

  // A waiting result stays put until it is taken.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(!empty && !pop)) |->
      (!empty && $stable(final_price) && $stable(in_the_money) &&
       $stable(batch_done) && $stable(payoff_estimate)))
    else $error("waiting result changed or vanished before pop");

endmodule

bind gbm_binary_option_monte_carlo_unit gbmbo_checker u_checker (.*);

`default_nettype wire

>>> sim/gbmbo_result_checker.sv
// Checker for the binary option Monte Carlo unit: predicts path and batch results and compares them.

module gbmbo_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [15:0] random_word,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] final_price,
  input  logic        in_the_money,
  input  logic        batch_done,
  input  logic [15:0] payoff_estimate,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          paths_checked,
  output int          batches_checked
);

  localparam int ND = gbmbo_pkg::DRAWS_PER_NORMAL;
  localparam int RB = gbmbo_pkg::RANDOM_BITS;
  localparam int SHR = (RB > 16) ? RB - 16 : 0;
  localparam int SHL = (RB < 16) ? 16 - RB : 0;

  gbmbo_pkg::cfg_t    cfg;
  logic [31:0]        price;
  logic [63:0]        draw_sum;
  int unsigned        draws;
  logic [15:0]        step_no;
  logic [23:0]        hits;
  logic [23:0]        paths_done;
  gbmbo_pkg::result_t results_due[$];

  function automatic logic [31:0] root_floor(input logic [63:0] n);
    logic [31:0] r;
    logic [31:0] c;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (32'd1 << b);
      if (64'(c) * 64'(c) <= n) r = c;
    end
    return r;
  endfunction

  // One uniform draw; every ND draws advance the walk, and a finished path queues a result.
  task automatic take_draw(input logic [15:0] w);
    logic [63:0]        center;
    logic [63:0]        dev;
    logic [63:0]        zmag;
    logic [63:0]        dmag;
    logic [63:0]        tmag;
    logic [127:0]       wide;
    logic               zneg;
    logic               dneg;
    logic               hit;
    longint             dsig;
    longint             f;
    logic [15:0]        span;
    logic [23:0]        batch;
    gbmbo_pkg::result_t r;
    draw_sum = draw_sum + (64'(w) & ((64'd1 << RB) - 64'd1)) + 64'd1;
    draws++;
    if (draws < ND) return;

    center = 64'(ND / 2) << RB;
    zneg = draw_sum < center;
    dev = zneg ? center - draw_sum : draw_sum - center;
    dev = (dev >> SHR) << SHL;
    wide = 128'(root_floor(64'(12 / ND) << 60)) * 128'(dev);
    zmag = 64'(wide >> 16);

    // The diffusion term is built from magnitudes, so it rounds toward zero.
    dsig = cfg.diffusion;
    dneg = dsig < 0;
    dmag = dneg ? 64'(-dsig) : 64'(dsig);
    wide = 128'(dmag) * 128'(zmag);
    tmag = 64'(wide >> 30);
    f = 64'sd1073741824 + longint'(cfg.drift);
    f = (zneg != dneg) ? f - longint'(tmag) : f + longint'(tmag);
    if (f < 0) f = 0;
    wide = (128'(price) * 128'(f)) >> 30;
    price = (wide > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];

    draw_sum = '0;
    draws = 0;
    step_no = step_no + 16'd1;
    span = (cfg.steps < 16'd2) ? 16'd2 : cfg.steps;
    if (step_no < span) return;

    hit = cfg.put_sel ? (price <= cfg.strike) : (price > cfg.strike);
    r.final_price = price;
    r.in_the_money = hit;
    r.batch_done = 1'b0;
    r.payoff_estimate = '0;
    hits = hits + 24'(hit);
    paths_done = paths_done + 24'd1;
    batch = (cfg.paths == 24'd0) ? 24'd1 : cfg.paths;
    if (paths_done >= batch && paths_done != 24'd0) begin
      r.batch_done = 1'b1;
      r.payoff_estimate = 16'((40'(cfg.discount) * 40'(hits)) / 40'(paths_done));
      hits = '0;
      paths_done = '0;
    end
    price = cfg.spot;
    step_no = 16'd1;
    results_due.push_back(r);
  endtask

  task automatic note_write();
    case (cfg_index)
      gbmbo_pkg::REG_DRIFT:     cfg.drift = cfg_data;
      gbmbo_pkg::REG_DIFFUSION: cfg.diffusion = cfg_data;
      gbmbo_pkg::REG_SPOT:      cfg.spot = cfg_data;
      gbmbo_pkg::REG_STRIKE:    cfg.strike = cfg_data;
      gbmbo_pkg::REG_STEPS:     cfg.steps = cfg_data[15:0];
      gbmbo_pkg::REG_PATHS:     cfg.paths = cfg_data[23:0];
      gbmbo_pkg::REG_DISCOUNT:  cfg.discount = cfg_data[15:0];
      gbmbo_pkg::REG_PUT:       cfg.put_sel = cfg_data[0];
      default: ;
    endcase
  endtask

  task automatic match_result();
    gbmbo_pkg::result_t want;
    if (results_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: price %h hit %b done %b estimate %h", $time,
               final_price, in_the_money, batch_done, payoff_estimate);
      return;
    end
    want = results_due.pop_front();
    if (final_price !== want.final_price) begin
      errors++;
      $display("%0t: final_price expected %h actual %h", $time, want.final_price, final_price);
    end
    if (in_the_money !== want.in_the_money) begin
      errors++;
      $display("%0t: in_the_money expected %b actual %b", $time, want.in_the_money,
               in_the_money);
    end
    if (batch_done !== want.batch_done) begin
      errors++;
      $display("%0t: batch_done expected %b actual %b", $time, want.batch_done, batch_done);
    end
    if (payoff_estimate !== want.payoff_estimate) begin
      errors++;
      $display("%0t: payoff_estimate expected %h actual %h", $time, want.payoff_estimate,
               payoff_estimate);
    end
    paths_checked++;
    if (want.batch_done) batches_checked++;
  endtask

  // The result transaction is checked before the new draw, so a result can never match
  // an expectation created at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      cfg = gbmbo_pkg::CFG_RESET;
      price = gbmbo_pkg::CFG_RESET.spot;
      draw_sum = '0;
      draws = 0;
      step_no = 16'd1;
      hits = '0;
      paths_done = '0;
      results_due.delete();
      errors = 0;
      paths_checked = 0;
      batches_checked = 0;
    end else begin
      if (pop && !empty) match_result();
      if (push && !full) take_draw(random_word);
      if (cfg_we) note_write();
    end
    pending = results_due.size();
  end

endmodule

>>> sim/tb.sv
// Testbench top for the binary option Monte Carlo unit: clock, reset, stimulus and verdict.

module tb;

  logic        clk = 1'b0;
  logic        rst;
  logic        push;
  logic        full;
  logic [15:0] random_word;
  logic        empty;
  logic        pop;
  logic [31:0] final_price;
  logic        in_the_money;
  logic        batch_done;
  logic [15:0] payoff_estimate;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  int errors;
  int pending;
  int paths_checked;
  int batches_checked;
  int words_sent = 0;
  int settings_used = 0;
  bit push_idle_on = 1'b1;
  bit pop_idle_on = 1'b1;

  always #1 clk = ~clk;

  gbm_binary_option_monte_carlo_unit dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .random_word(random_word),
    .empty(empty),
    .pop(pop),
    .final_price(final_price),
    .in_the_money(in_the_money),
    .batch_done(batch_done),
    .payoff_estimate(payoff_estimate),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  gbmbo_result_checker chk (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .random_word(random_word),
    .empty(empty),
    .pop(pop),
    .final_price(final_price),
    .in_the_money(in_the_money),
    .batch_done(batch_done),
    .payoff_estimate(payoff_estimate),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(errors),
    .pending(pending),
    .paths_checked(paths_checked),
    .batches_checked(batches_checked)
  );

  initial begin
    #1000000;
    $display("[gbm_binary_option_monte_carlo_unit] ERROR");
    $finish;
  end

  // Result side: a random stall before each transaction, none while pop_idle_on is clear.
  initial begin : result_drain
    int gap;
    pop = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      gap = pop_idle_on ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  task automatic set_reg(input gbmbo_pkg::reg_index_t idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [31:0] drift, input logic [31:0] diffusion,
                               input logic [31:0] spot, input logic [31:0] strike,
                               input logic [15:0] steps, input logic [23:0] paths,
                               input logic [15:0] discount, input logic put_sel);
    set_reg(gbmbo_pkg::REG_DRIFT, drift);
    set_reg(gbmbo_pkg::REG_DIFFUSION, diffusion);
    set_reg(gbmbo_pkg::REG_SPOT, spot);
    set_reg(gbmbo_pkg::REG_STRIKE, strike);
    set_reg(gbmbo_pkg::REG_STEPS, 32'(steps));
    set_reg(gbmbo_pkg::REG_PATHS, 32'(paths));
    set_reg(gbmbo_pkg::REG_DISCOUNT, 32'(discount));
    set_reg(gbmbo_pkg::REG_PUT, 32'(put_sel));
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  task automatic feed_word(input logic [15:0] w);
    int gap;
    gap = push_idle_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    random_word <= w;
    push <= 1'b1;
    do @(posedge clk); while (full);
    @(negedge clk);
    words_sent++;
  endtask

  // Stop sending, let every predicted result drain, then cover steps still in the
  // back end that produce no result before the registers change.
  task automatic drain_unit();
    push <= 1'b0;
    wait (pending == 0);
    repeat (100) @(negedge clk);
  endtask

  task automatic random_settings();
    logic [31:0] drift;
    logic [31:0] diffusion;
    logic [31:0] spot;
    logic [31:0] strike;
    logic [15:0] steps;
    logic [23:0] paths;
    logic [15:0] discount;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      drift = $urandom_range(0, 80000) - 40000;
      diffusion = $urandom_range(0, 20000000) - 10000000;
    end else begin
      case ($urandom_range(0, 2))
        0: drift = 32'h8000_0000;
        1: drift = 32'h7FFF_FFFF;
        default: drift = $urandom;
      endcase
      case ($urandom_range(0, 2))
        0: diffusion = 32'h8000_0000;
        1: diffusion = 32'h7FFF_FFFF;
        default: diffusion = $urandom;
      endcase
    end
    case ($urandom_range(0, 9))
      0: spot = 32'h0000_0000;
      1: spot = 32'hFFFF_FFFF;
      2: spot = $urandom;
      default: spot = $urandom_range(32'h0010_0000, 32'h0100_0000);
    endcase
    case ($urandom_range(0, 9))
      0: strike = 32'h0000_0000;
      1: strike = 32'hFFFF_FFFF;
      2: strike = $urandom;
      3: strike = spot;
      default: strike = spot + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
    case ($urandom_range(0, 19))
      0: steps = 16'd0;
      1: steps = 16'd1;
      2: steps = 16'hFFFF;
      3: steps = 16'($urandom_range(6, 12));
      default: steps = 16'($urandom_range(2, 5));
    endcase
    case ($urandom_range(0, 19))
      0: paths = 24'd0;
      1: paths = 24'hFF_FFFF;
      default: paths = 24'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 5))
      0: discount = 16'h0000;
      1: discount = 16'hFFFF;
      default: discount = 16'($urandom);
    endcase
    load_settings(drift, diffusion, spot, strike, steps, paths, discount,
                  1'($urandom_range(0, 1)));
  endtask

  initial begin : stimulus
    int          n;
    logic [15:0] w;
    rst = 1'b1;
    push = 1'b0;
    random_word = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Short path with a flat walk: the price equals the strike, so a call misses;
    // a zero discount gives a zero estimate. The spot change applies to the next path.
    load_settings(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0064_0000, 16'd1, 24'd1, 16'h0000, 1'b0);
    for (int i = 0; i < 12; i++) feed_word(i[0] ? 16'hAAAA : 16'h5555);
    drain_unit();

    // From the top price, one step up saturates and one step down floors the factor,
    // ending at zero; a put with a zero strike pays on the tie, and an empty batch acts as one.
    load_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 16'd3, 24'd0,
                  16'hFFFF, 1'b1);
    for (int i = 0; i < 12; i++) feed_word(16'hFFFF);
    for (int i = 0; i < 12; i++) feed_word(16'h0000);
    drain_unit();

    // Most negative drift and diffusion on a zero-length path setting.
    load_settings(32'h8000_0000, 32'h8000_0000, 32'h0001_0000, 32'h0, 16'd0, 24'd2,
                  16'h8000, 1'b0);
    for (int i = 0; i < 12; i++) feed_word(16'($urandom));
    drain_unit();

    while (words_sent < 1330) begin
      random_settings();
      push_idle_on = $urandom_range(0, 3) != 0;
      pop_idle_on = $urandom_range(0, 3) != 0;
      n = $urandom_range(24, 150);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0: w = 16'h0000;
          1: w = 16'hFFFF;
          default: w = 16'($urandom);
        endcase
        feed_word(w);
      end
      drain_unit();
    end

    $display("Sent %0d random words under %0d register settings.", words_sent, settings_used);
    $display("Checked %0d path results, %0d of them batch estimates.", paths_checked,
             batches_checked);
    if (errors == 0) begin
      $display("[gbm_binary_option_monte_carlo_unit] OK");
    end else begin
      $display("[gbm_binary_option_monte_carlo_unit] ERROR");
    end
    $finish;
  end

endmodule
